### rtl/tlik_pkg.sv
// Shared types, constants and helpers for the two-link leg solver.
// No dependencies; every other file imports this package.
package tlik_pkg;

   localparam int LEN_W      = 16;
   localparam int ANG_W      = 16;
   localparam int IDX_W      = 8;
   localparam int QUO_W      = 31;
   localparam int DEN_W      = 34;
   localparam int REM_W      = 35;
   localparam int RAD_W      = 62;
   localparam int CRD_W      = 34;
   localparam int DIV_STEPS  = 31;
   localparam int SQRT_STEPS = 31;
   localparam int ATAN_LEN   = 24;

   localparam logic [IDX_W-1:0] REG_THIGH = 8'd0;
   localparam logic [IDX_W-1:0] REG_SHANK = 8'd1;

   localparam logic [LEN_W-1:0] THIGH_RESET = 16'd6554;
   localparam logic [LEN_W-1:0] SHANK_RESET = 16'd6554;

   localparam logic [QUO_W-1:0]        ONE_Q30     = 31'h4000_0000;
   localparam logic [RAD_W-1:0]        ONE_Q60     = 62'h1000_0000_0000_0000;
   localparam logic signed [CRD_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [19:0]      PI_Q13      = 20'sd25736;
   localparam logic signed [CRD_W:0]   ROUND_HALF  = 35'sd65536;

   typedef struct packed {
      logic                    flag;
      logic signed [ANG_W-1:0] front;
      logic signed [ANG_W-1:0] lateral;
      logic signed [ANG_W-1:0] foot;
   } meta_type;

   typedef struct packed {
      logic             neg;
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                  valid;
      meta_type              meta;
      div_lane_type [1:0]    lane;
   } div_word_type;

   typedef struct packed {
      logic             neg;
      logic [QUO_W-1:0] quo;
      logic [RAD_W-1:0] rad;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] root;
   } sqrt_lane_type;

   typedef struct packed {
      logic                  valid;
      meta_type              meta;
      sqrt_lane_type [1:0]   lane;
   } sqrt_word_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [CRD_W-1:0] z;
   } cordic_lane_type;

   typedef struct packed {
      logic                    valid;
      meta_type                meta;
      cordic_lane_type [1:0]   lane;
   } cordic_word_type;

   function automatic logic signed [CRD_W-1:0] atan_entry(input logic [4:0] idx);
      logic signed [CRD_W-1:0] v;
      unique case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [ANG_W-1:0] sat16(input logic signed [19:0] v);
      logic signed [ANG_W-1:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[ANG_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/tlik_ifs.sv
// Valid/ready channel interfaces for pose words, angle words and register writes.
// Depends on tlik_pkg for field widths.
interface tlik_req_if import tlik_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [LEN_W-1:0]        leg_length;
   logic signed [ANG_W-1:0] front_angle;
   logic signed [ANG_W-1:0] lateral_angle;
   logic signed [ANG_W-1:0] foot_angle;
   modport source (output valid, leg_length, front_angle, lateral_angle, foot_angle,
                   input ready);
   modport sink (input valid, leg_length, front_angle, lateral_angle, foot_angle,
                 output ready);
endinterface

interface tlik_rsp_if import tlik_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [ANG_W-1:0] hip_angle;
   logic signed [ANG_W-1:0] knee_angle;
   logic signed [ANG_W-1:0] ankle_angle;
   logic signed [ANG_W-1:0] lateral_out;
   logic                    unreachable;
   modport source (output valid, hip_angle, knee_angle, ankle_angle, lateral_out,
                   unreachable, input ready);
   modport sink (input valid, hip_angle, knee_angle, ankle_angle, lateral_out,
                 unreachable, output ready);
endinterface

interface tlik_csr_if import tlik_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [LEN_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/tlik_div_cell.sv
// One restoring-division cell: one quotient bit per lane per cycle while enabled.
// Depends on tlik_pkg.
module tlik_div_cell import tlik_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         enable,
   input  div_word_type word_in,
   output div_word_type word_out
);

   div_word_type word_ff;
   div_word_type word_in_next;

   always_comb begin
      logic             ge;
      logic [REM_W-1:0] diff;
      word_in_next = word_in;
      for (int k = 0; k < 2; k++) begin
         ge   = word_in.lane[k].rem >= {1'b0, word_in.lane[k].den};
         diff = ge ? word_in.lane[k].rem - {1'b0, word_in.lane[k].den} : word_in.lane[k].rem;
         word_in_next.lane[k].rem = {diff[REM_W-2:0], 1'b0};
         word_in_next.lane[k].quo = {word_in.lane[k].quo[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff.valid <= word_in_next.valid;
      end
      if (enable) begin
         word_ff.meta <= word_in_next.meta;
         word_ff.lane <= word_in_next.lane;
      end
   end

   assign word_out = word_ff;

endmodule

### rtl/tlik_sqrt_cell.sv
// One integer square-root cell: one root bit per lane per cycle while enabled.
// Depends on tlik_pkg.
module tlik_sqrt_cell import tlik_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  sqrt_word_type word_in,
   output sqrt_word_type word_out
);

   sqrt_word_type word_ff;
   sqrt_word_type word_in_next;

   always_comb begin
      logic             ge;
      logic [REM_W-1:0] cat;
      logic [REM_W-1:0] trial;
      word_in_next = word_in;
      for (int k = 0; k < 2; k++) begin
         cat   = {word_in.lane[k].rem[REM_W-3:0], word_in.lane[k].rad[RAD_W-1 -: 2]};
         trial = {2'b00, word_in.lane[k].root, 2'b01};
         ge    = cat >= trial;
         word_in_next.lane[k].rem  = ge ? cat - trial : cat;
         word_in_next.lane[k].root = {word_in.lane[k].root[QUO_W-2:0], ge};
         word_in_next.lane[k].rad  = {word_in.lane[k].rad[RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff.valid <= word_in_next.valid;
      end
      if (enable) begin
         word_ff.meta <= word_in_next.meta;
         word_ff.lane <= word_in_next.lane;
      end
   end

   assign word_out = word_ff;

endmodule

### rtl/tlik_cordic_cell.sv
// One vectoring CORDIC cell: one micro-rotation per lane per cycle while enabled.
// Depends on tlik_pkg for the arctangent table.
module tlik_cordic_cell import tlik_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            enable,
   input  cordic_word_type word_in,
   output cordic_word_type word_out
);

   localparam logic [4:0] IDX = 5'(STAGE);

   cordic_word_type word_ff;
   cordic_word_type word_in_next;

   always_comb begin
      logic signed [CRD_W-1:0] xs;
      logic signed [CRD_W-1:0] ys;
      word_in_next = word_in;
      for (int k = 0; k < 2; k++) begin
         xs = word_in.lane[k].x >>> STAGE;
         ys = word_in.lane[k].y >>> STAGE;
         if (!word_in.lane[k].y[CRD_W-1]) begin
            word_in_next.lane[k].x = word_in.lane[k].x + ys;
            word_in_next.lane[k].y = word_in.lane[k].y - xs;
            word_in_next.lane[k].z = word_in.lane[k].z + atan_entry(IDX);
         end else begin
            word_in_next.lane[k].x = word_in.lane[k].x - ys;
            word_in_next.lane[k].y = word_in.lane[k].y + xs;
            word_in_next.lane[k].z = word_in.lane[k].z - atan_entry(IDX);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (enable) begin
         word_ff.valid <= word_in_next.valid;
      end
      if (enable) begin
         word_ff.meta <= word_in_next.meta;
         word_ff.lane <= word_in_next.lane;
      end
   end

   assign word_out = word_ff;

endmodule

### rtl/two_link_leg_inverse_kinematics.sv
// Two-link leg solver: pose word in, hip/knee/ankle/lateral angle word out.
// Depends on tlik_pkg, tlik_ifs and the div, sqrt and CORDIC cells.
//
// Takes one pose word per cycle unless the chain holds, and returns one angle
// word per pose, in order. It has three front stages (register, products,
// cosine setup), 31 division cells, one squaring stage, 31 square-root cells,
// one CORDIC setup stage, ANGLE_STAGES CORDIC cells and two output stages.
// The whole chain advances together; it holds only while its last stage and
// the output register are both full and the output is not taken. Register
// writes are accepted every cycle and take effect for the next pose word.
module two_link_leg_inverse_kinematics import tlik_pkg::*; #(
   parameter int ANGLE_STAGES = 16
) (
   input  logic       clock,
   input  logic       reset,
   tlik_req_if.sink   req_ch,
   tlik_rsp_if.source rsp_ch,
   tlik_csr_if.sink   csr_ch
);

   logic [LEN_W-1:0] thigh_ff;
   logic [LEN_W-1:0] shank_ff;
   logic             en;

   always_ff @(posedge clock) begin
      if (reset) begin
         thigh_ff <= THIGH_RESET;
         shank_ff <= SHANK_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == REG_THIGH) begin
            thigh_ff <= csr_ch.data;
         end
         if (csr_ch.index == REG_SHANK) begin
            shank_ff <= csr_ch.data;
         end
      end
   end
   assign csr_ch.ready = 1'b1;

   // input register
   logic             p0_valid_ff;
   logic [LEN_W-1:0] p0_len_ff, p0_t_ff, p0_s_ff;
   meta_type         p0_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= req_ch.valid;
      end
      if (en) begin
         p0_len_ff          <= req_ch.leg_length;
         p0_t_ff            <= thigh_ff;
         p0_s_ff            <= shank_ff;
         p0_meta_ff.flag    <= 1'b0;
         p0_meta_ff.front   <= req_ch.front_angle;
         p0_meta_ff.lateral <= req_ch.lateral_angle;
         p0_meta_ff.foot    <= req_ch.foot_angle;
      end
   end
   assign req_ch.ready = en;

   // products
   logic        p1_valid_ff;
   logic [31:0] p1_tt_ff, p1_ss_ff, p1_ll_ff, p1_tl_ff, p1_ts_ff;
   meta_type    p1_meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= p0_valid_ff;
      end
      if (en) begin
         p1_tt_ff   <= p0_t_ff * p0_t_ff;
         p1_ss_ff   <= p0_s_ff * p0_s_ff;
         p1_ll_ff   <= p0_len_ff * p0_len_ff;
         p1_tl_ff   <= p0_t_ff * p0_len_ff;
         p1_ts_ff   <= p0_t_ff * p0_s_ff;
         p1_meta_ff <= p0_meta_ff;
      end
   end

   // cosine setup: clamp forces num = den = 1 so the quotient is exactly one
   div_word_type div_head_in, div_head_ff;

   always_comb begin
      logic signed [REM_W-1:0] num [2];
      logic [DEN_W-1:0]        den [2];
      logic [DEN_W-1:0]        mag;
      logic                    clamp;
      num[0] = $signed({3'b000, p1_tt_ff}) + $signed({3'b000, p1_ll_ff})
             - $signed({3'b000, p1_ss_ff});
      num[1] = $signed({3'b000, p1_tt_ff}) + $signed({3'b000, p1_ss_ff})
             - $signed({3'b000, p1_ll_ff});
      den[0] = {1'b0, p1_tl_ff, 1'b0};
      den[1] = {1'b0, p1_ts_ff, 1'b0};
      div_head_in.valid = p1_valid_ff;
      div_head_in.meta  = p1_meta_ff;
      for (int k = 0; k < 2; k++) begin
         mag   = num[k][REM_W-1] ? DEN_W'(-num[k]) : DEN_W'(num[k]);
         clamp = (den[k] == '0) || (mag > den[k]);
         if (clamp) begin
            div_head_in.meta.flag = 1'b1;
         end
         div_head_in.lane[k].neg = num[k][REM_W-1];
         div_head_in.lane[k].rem = clamp ? REM_W'(1) : {1'b0, mag};
         div_head_in.lane[k].den = clamp ? DEN_W'(1) : den[k];
         div_head_in.lane[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_head_ff.valid <= 1'b0;
      end else if (en) begin
         div_head_ff.valid <= div_head_in.valid;
      end
      if (en) begin
         div_head_ff.meta <= div_head_in.meta;
         div_head_ff.lane <= div_head_in.lane;
      end
   end

   div_word_type div_w [DIV_STEPS+1];
   assign div_w[0] = div_head_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      tlik_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .word_in  (div_w[g]),
         .word_out (div_w[g+1])
      );
   end

   // sine radicand: 1 - c*c; a zero quotient counts as a positive cosine
   sqrt_word_type sq_head_in, sq_head_ff;

   always_comb begin
      logic [RAD_W-1:0] csq;
      sq_head_in.valid = div_w[DIV_STEPS].valid;
      sq_head_in.meta  = div_w[DIV_STEPS].meta;
      for (int k = 0; k < 2; k++) begin
         csq = RAD_W'(div_w[DIV_STEPS].lane[k].quo) * RAD_W'(div_w[DIV_STEPS].lane[k].quo);
         sq_head_in.lane[k].neg  = div_w[DIV_STEPS].lane[k].neg &&
                                   (div_w[DIV_STEPS].lane[k].quo != '0);
         sq_head_in.lane[k].quo  = div_w[DIV_STEPS].lane[k].quo;
         sq_head_in.lane[k].rad  = ONE_Q60 - csq;
         sq_head_in.lane[k].rem  = '0;
         sq_head_in.lane[k].root = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_head_ff.valid <= 1'b0;
      end else if (en) begin
         sq_head_ff.valid <= sq_head_in.valid;
      end
      if (en) begin
         sq_head_ff.meta <= sq_head_in.meta;
         sq_head_ff.lane <= sq_head_in.lane;
      end
   end

   sqrt_word_type sq_w [SQRT_STEPS+1];
   assign sq_w[0] = sq_head_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      tlik_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .word_in  (sq_w[g]),
         .word_out (sq_w[g+1])
      );
   end

   // CORDIC setup: rotate by -pi/2 for a negative cosine
   cordic_word_type cr_head_in, cr_head_ff;

   always_comb begin
      logic signed [CRD_W-1:0] cv;
      logic signed [CRD_W-1:0] sv;
      cr_head_in.valid = sq_w[SQRT_STEPS].valid;
      cr_head_in.meta  = sq_w[SQRT_STEPS].meta;
      for (int k = 0; k < 2; k++) begin
         cv = $signed({3'b000, sq_w[SQRT_STEPS].lane[k].quo});
         sv = $signed({3'b000, sq_w[SQRT_STEPS].lane[k].root});
         if (sq_w[SQRT_STEPS].lane[k].neg) begin
            cr_head_in.lane[k].x = sv;
            cr_head_in.lane[k].y = cv;
            cr_head_in.lane[k].z = HALF_PI_Q30;
         end else begin
            cr_head_in.lane[k].x = cv;
            cr_head_in.lane[k].y = sv;
            cr_head_in.lane[k].z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_head_ff.valid <= 1'b0;
      end else if (en) begin
         cr_head_ff.valid <= cr_head_in.valid;
      end
      if (en) begin
         cr_head_ff.meta <= cr_head_in.meta;
         cr_head_ff.lane <= cr_head_in.lane;
      end
   end

   cordic_word_type cr_w [ANGLE_STAGES+1];
   assign cr_w[0] = cr_head_ff;

   for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cordic
      tlik_cordic_cell #(.STAGE(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (en),
         .word_in  (cr_w[g]),
         .word_out (cr_w[g+1])
      );
   end

   // round to Q3.13
   logic                p5_valid_ff;
   logic signed [17:0]  p5_a_ff [2];
   meta_type            p5_meta_ff;

   always_ff @(posedge clock) begin
      logic signed [CRD_W:0] zr;
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else if (en) begin
         p5_valid_ff <= cr_w[ANGLE_STAGES].valid;
      end
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            zr = CRD_W'(0) + $signed({cr_w[ANGLE_STAGES].lane[k].z[CRD_W-1],
                                      cr_w[ANGLE_STAGES].lane[k].z}) + ROUND_HALF;
            p5_a_ff[k] <= zr[CRD_W:17];
         end
         p5_meta_ff <= cr_w[ANGLE_STAGES].meta;
      end
   end

   assign en = !p5_valid_ff || !rsp_ch.valid || rsp_ch.ready;

   // output register
   logic                    rsp_valid_ff;
   logic signed [ANG_W-1:0] hip_ff, knee_ff, ankle_ff, lateral_ff;
   logic                    unreach_ff;

   always_ff @(posedge clock) begin
      logic signed [19:0] hip;
      logic signed [19:0] knee;
      logic signed [19:0] ankle;
      logic signed [19:0] lat;
      hip   = -20'(p5_a_ff[0]) - 20'(p5_meta_ff.front);
      knee  = PI_Q13 - 20'(p5_a_ff[1]);
      ankle = 20'(p5_meta_ff.foot) - hip - knee;
      lat   = -20'(p5_meta_ff.lateral);
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en && p5_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (en && p5_valid_ff) begin
         hip_ff     <= sat16(hip);
         knee_ff    <= sat16(knee);
         ankle_ff   <= sat16(ankle);
         lateral_ff <= sat16(lat);
         unreach_ff <= p5_meta_ff.flag;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.hip_angle   = hip_ff;
   assign rsp_ch.knee_angle  = knee_ff;
   assign rsp_ch.ankle_angle = ankle_ff;
   assign rsp_ch.lateral_out = lateral_ff;
   assign rsp_ch.unreachable = unreach_ff;

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (p5_valid_ff && rsp_valid_ff && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while chain is stalled");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      div_w[DIV_STEPS].valid |-> (div_w[DIV_STEPS].lane[0].quo <= ONE_Q30 &&
                                  div_w[DIV_STEPS].lane[1].quo <= ONE_Q30))
      else $error("cosine magnitude above one");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      sq_w[SQRT_STEPS].valid |-> (sq_w[SQRT_STEPS].lane[0].root <= ONE_Q30 &&
                                  sq_w[SQRT_STEPS].lane[1].root <= ONE_Q30))
      else $error("sine magnitude above one");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

endmodule
